// ===== rtl/ipv4p_pkg.sv =====
// Shared types, codes and character helpers of the dotted IPv4 address parser.
`default_nettype none
package ipv4p_pkg;

  // Parse phase codes.
  localparam logic [2:0] PH_SKIP = 3'd0;
  localparam logic [2:0] PH_SIGN = 3'd1;
  localparam logic [2:0] PH_ZERO = 3'd2;
  localparam logic [2:0] PH_HEXP = 3'd3;
  localparam logic [2:0] PH_DIGS = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  // Radix codes.
  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_OCT = 2'd1;
  localparam logic [1:0] RX_HEX = 2'd2;

  localparam logic [4:0] NO_DIGIT = 5'd16;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  localparam logic [1:0]  LAST_PART_CNT = 2'd3;
  localparam logic [31:0] MAX_24 = 32'h00FF_FFFF;
  localparam logic [31:0] MAX_16 = 32'h0000_FFFF;
  localparam logic [31:0] MAX_8  = 32'h0000_00FF;

  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  radix;
    logic [31:0] acc;
    logic        ovf;
    logic        neg;
    logic [1:0]  part_cnt;
    logic [31:0] earlier;   // earlier parts, already shifted and merged
    logic        rejected;
  } state_t;

  localparam state_t ST_RESET = '{
    phase:    PH_SKIP,
    radix:    RX_DEC,
    acc:      32'h0,
    ovf:      1'b0,
    neg:      1'b0,
    part_cnt: 2'd0,
    earlier:  32'h0,
    rejected: 1'b0
  };

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) d = 5'(c - CH_ZERO);
    else if (c >= CH_LA && c <= CH_LF) d = 5'(c - CH_LA + 8'd10);
    else if (c >= CH_UA && c <= CH_UF) d = 5'(c - CH_UA + 8'd10);
    return d;
  endfunction

  function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [1:0] rx);
    logic [4:0] d;
    d = hex_digit(c);
    if (rx == RX_OCT) return (d < 5'd8) ? d : NO_DIGIT;
    if (rx == RX_HEX) return d;
    return (d < 5'd10) ? d : NO_DIGIT;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ipv4p_in_if.sv =====
// Character input channel of the address parser.
`default_nettype none
interface ipv4p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface
`default_nettype wire

// ===== rtl/ipv4p_out_if.sv =====
// Result channel of the address parser.
`default_nettype none
interface ipv4p_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [31:0] address;

  modport source (output valid, output valid_res, output address, input ready);
  modport sink (input valid, input valid_res, input address, output ready);
endinterface
`default_nettype wire

// ===== rtl/ipv4_text_address_parser_top.sv =====
// Top level of the dotted IPv4 text address parser.
// One character is taken per beat and the block sustains one beat per clock cycle while
// no zero byte waits behind an untaken result. A character is first captured in an input
// register; in the next cycle, unless it is a zero byte held back in that way, the parse
// state advances through one pass of combinational logic, and a zero byte loads the
// result register, from which the result is offered to the sink. Input ready drops only
// while a zero byte waits behind a result that the sink has not yet taken.
// Parsing follows the classic dotted-quad rules: up to four dot-separated parts, each in
// decimal, octal (leading 0) or hex (0x), with an invalid string reported as
// valid_res = 0 and address = 0.
`default_nettype none
module ipv4_text_address_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  ipv4p_in_if.sink    in_ch,
  ipv4p_out_if.source out_ch
);
  import ipv4p_pkg::*;

  logic        in_v_r;
  logic [7:0]  in_char_r;
  state_t      st_r;
  state_t      st_nxt;
  logic        out_v_r;
  logic        out_res_r;
  logic [31:0] out_addr_r;
  logic        res_valid;
  logic [31:0] res_addr;
  logic        is_end;
  logic        fire;

  ipv4p_part_engine u_engine (
    .st        (st_r),
    .char_code (in_char_r),
    .st_nxt    (st_nxt)
  );

  ipv4p_assemble u_assemble (
    .st        (st_nxt),
    .valid_res (res_valid),
    .address   (res_addr)
  );

  assign is_end      = (in_char_r == CH_NUL);
  assign fire        = in_v_r && (!is_end || !out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= ST_RESET;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_v_r    <= 1'b1;
        in_char_r <= in_ch.char_code;
      end else if (fire) begin
        in_v_r <= 1'b0;
      end

      if (fire) begin
        st_r <= is_end ? ST_RESET : st_nxt;
      end

      if (fire && is_end) begin
        out_v_r    <= 1'b1;
        out_res_r  <= res_valid;
        out_addr_r <= res_addr;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.valid_res = out_res_r;
  assign out_ch.address   = out_addr_r;

endmodule
`default_nettype wire

// ===== rtl/ipv4p_part_engine.sv =====
// Per-character next-state logic: whitespace, sign, radix prefix, digit accumulate, dots.
`default_nettype none
module ipv4p_part_engine (
  input  ipv4p_pkg::state_t st,
  input  logic [7:0]        char_code,
  output ipv4p_pkg::state_t st_nxt
);
  import ipv4p_pkg::*;

  logic [4:0]  dig;
  logic [4:0]  hdig;
  logic [35:0] prod;
  logic [35:0] acc_sum;
  logic [31:0] part_val;
  logic        is_dot;

  assign dig    = digit_of(char_code, st.radix);
  assign hdig   = hex_digit(char_code);
  assign is_dot = (char_code == CH_DOT);

  always_comb begin
    unique case (st.radix)
      RX_OCT:  prod = {1'b0, st.acc, 3'b0};
      RX_HEX:  prod = {st.acc, 4'b0};
      default: prod = {1'b0, st.acc, 3'b0} + {3'b0, st.acc, 1'b0};
    endcase
  end

  assign acc_sum  = prod + 36'(dig);
  assign part_val = st.ovf ? 32'hFFFF_FFFF : (st.neg ? (32'h0 - st.acc) : st.acc);

  always_comb begin
    logic        do_start;
    logic        do_take;
    logic        fin_en;
    logic        fin_dot;
    logic [31:0] fin_val;

    st_nxt   = st;
    do_start = 1'b0;
    do_take  = 1'b0;
    fin_en   = 1'b0;
    fin_dot  = 1'b0;
    fin_val  = 32'h0;

    unique case (st.phase)
      PH_SKIP: begin
        if (char_code == CH_NUL || !is_blank(char_code)) begin
          if (char_code == CH_PLUS || char_code == CH_MINUS) begin
            st_nxt.neg   = (char_code == CH_MINUS);
            st_nxt.phase = PH_SIGN;
          end else begin
            do_start = 1'b1;
          end
        end
      end
      PH_SIGN: do_start = 1'b1;
      PH_ZERO: begin
        if (char_code == CH_LX || char_code == CH_UX) st_nxt.phase = PH_HEXP;
        else do_take = 1'b1;
      end
      PH_HEXP: begin
        if (hdig != NO_DIGIT) begin
          st_nxt.radix = RX_HEX;
          st_nxt.acc   = 32'(hdig);
          st_nxt.phase = PH_DIGS;
        end else begin
          // A bare "0x" yields zero and closes the string.
          fin_en = 1'b1;
        end
      end
      PH_DIGS: do_take = 1'b1;
      default: ;
    endcase

    if (do_start) begin
      if (char_code == CH_ZERO) begin
        st_nxt.acc   = 32'h0;
        st_nxt.radix = RX_OCT;
        st_nxt.phase = PH_ZERO;
      end else if (char_code >= CH_ONE && char_code <= CH_NINE) begin
        st_nxt.acc   = 32'(char_code - CH_ZERO);
        st_nxt.radix = RX_DEC;
        st_nxt.phase = PH_DIGS;
      end else begin
        st_nxt.rejected = 1'b1;
        st_nxt.phase    = PH_DONE;
      end
    end

    if (do_take) begin
      if (dig == NO_DIGIT) begin
        fin_en  = 1'b1;
        fin_dot = is_dot;
        fin_val = part_val;
      end else begin
        st_nxt.ovf   = st.ovf | (acc_sum[35:32] != 4'h0);
        st_nxt.acc   = acc_sum[31:0];
        st_nxt.phase = PH_DIGS;
      end
    end

    if (fin_en) begin
      st_nxt.ovf   = 1'b0;
      st_nxt.neg   = 1'b0;
      st_nxt.radix = RX_DEC;
      if (fin_dot && st.part_cnt != LAST_PART_CNT) begin
        // Earlier parts are shifted into place and merged here, no range check.
        case (st.part_cnt)
          2'd0:    st_nxt.earlier = {fin_val[7:0], 24'h0};
          2'd1:    st_nxt.earlier = st.earlier | {fin_val[15:0], 16'h0};
          default: st_nxt.earlier = st.earlier | {fin_val[23:0], 8'h0};
        endcase
        st_nxt.part_cnt = st.part_cnt + 2'd1;
        st_nxt.acc      = 32'h0;
        st_nxt.phase    = PH_SKIP;
      end else begin
        st_nxt.acc   = fin_val;
        st_nxt.phase = PH_DONE;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ipv4p_assemble.sv =====
// Final range check of the last part and merge with the earlier parts.
`default_nettype none
module ipv4p_assemble (
  input  ipv4p_pkg::state_t st,
  output logic              valid_res,
  output logic [31:0]       address
);
  import ipv4p_pkg::*;

  logic ok;

  always_comb begin
    ok = !st.rejected && (st.phase == PH_DONE);
    case (st.part_cnt)
      2'd1:    ok = ok && (st.acc <= MAX_24);
      2'd2:    ok = ok && (st.acc <= MAX_16);
      2'd3:    ok = ok && (st.acc <= MAX_8);
      default: ;
    endcase
  end

  assign valid_res = ok;
  assign address   = !ok ? 32'h0 :
                     (st.part_cnt == 2'd0) ? st.acc : (st.acc | st.earlier);

endmodule
`default_nettype wire

// ===== rtl/ipv4p_checker.sv =====
// Port-level checks of the address parser and their binding to the top level.
`default_nettype none
module ipv4p_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_char_code,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_valid_res,
  input logic [31:0] out_address
);
  import ipv4p_pkg::*;

  // A result held back by the sink stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_address == 32'h0)
    else $error("rejected string carries a nonzero address");

  // Input is only held off by a stalled result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // A new result is offered only after a zero byte has been accepted.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_char_code == CH_NUL, 2))
    else $error("result without a terminating zero byte");

endmodule

bind ipv4_text_address_parser_top ipv4p_checker u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_char_code  (in_ch.char_code),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_valid_res (out_ch.valid_res),
  .out_address   (out_ch.address)
);
`default_nettype wire
